@@ rtl/pcd_pkg.sv @@
package pcd_pkg;

  localparam int unsigned PitchW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned GainW  = 17;

  localparam logic [GainW-1:0] GAIN_ONE = 17'd65536;

  // operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ALPHA   = 2'd1;
  localparam logic [1:0] REG_ENTER   = 2'd2;
  localparam logic [1:0] REG_EXIT    = 2'd3;

  localparam logic [15:0]       TIMEOUT_RST = 16'd1000;
  localparam logic [GainW-1:0]  ALPHA_RST   = 17'd6554;
  localparam logic [PitchW-1:0] ENTER_RST   = 16'hFD35;  // -715
  localparam logic [PitchW-1:0] EXIT_RST    = 16'hFF71;  // -143

  typedef struct packed {
    logic [15:0]       min_climb_ms;
    logic [GainW-1:0]  alpha_gain;
    logic [PitchW-1:0] enter_threshold;
    logic [PitchW-1:0] exit_threshold;
  } cfg_t;

  typedef struct packed {
    logic              climb_active;
    logic [PitchW-1:0] pitch_bias;
    logic [TimeW-1:0]  entry_time;
  } state_t;

  typedef struct packed {
    state_t nxt;
    logic   climb_started;
  } step_t;

endpackage

@@ rtl/pcd_cfg.sv @@
module pcd_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [pcd_pkg::GainW-1:0] cfg_data,
  output pcd_pkg::cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_climb_ms    <= pcd_pkg::TIMEOUT_RST;
      cfg.alpha_gain      <= pcd_pkg::ALPHA_RST;
      cfg.enter_threshold <= pcd_pkg::ENTER_RST;
      cfg.exit_threshold  <= pcd_pkg::EXIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pcd_pkg::REG_TIMEOUT: cfg.min_climb_ms    <= cfg_data[15:0];
        pcd_pkg::REG_ALPHA:   cfg.alpha_gain      <= cfg_data;
        pcd_pkg::REG_ENTER:   cfg.enter_threshold <= cfg_data[15:0];
        pcd_pkg::REG_EXIT:    cfg.exit_threshold  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/pcd_step.sv @@
module pcd_step (
  input  logic                       operation,
  input  logic [pcd_pkg::PitchW-1:0] pitch,
  input  logic [pcd_pkg::TimeW-1:0]  timestamp_ms,
  input  pcd_pkg::state_t            cur,
  input  pcd_pkg::cfg_t              cfg,
  output pcd_pkg::step_t             res
);

  logic                       restart;
  logic signed [16:0]         corrected;
  logic [pcd_pkg::TimeW-1:0]  elapsed;
  logic                       enter_hit;
  logic                       exit_ok;
  logic                       active_mid;
  logic [15:0]                prev;
  logic [pcd_pkg::GainW-1:0]  gain;
  logic signed [16:0]         diff;
  logic signed [34:0]         prod;
  logic signed [34:0]         prod_sh;
  logic [15:0]                ema;

  assign restart   = (operation == pcd_pkg::OP_RESTART);
  assign corrected = $signed({pitch[15], pitch}) - $signed({cur.pitch_bias[15], cur.pitch_bias});
  assign elapsed   = timestamp_ms - cur.entry_time;

  assign enter_hit = !cur.climb_active &&
                     (corrected < $signed({cfg.enter_threshold[15], cfg.enter_threshold}));
  assign exit_ok   = cur.climb_active &&
                     (corrected >= $signed({cfg.exit_threshold[15], cfg.exit_threshold})) &&
                     (elapsed > {16'd0, cfg.min_climb_ms});
  assign active_mid = enter_hit | (cur.climb_active & ~exit_ok);

  // exit clears the bias before the average runs
  assign prev = exit_ok ? 16'd0 : cur.pitch_bias;
  assign gain = (cfg.alpha_gain > pcd_pkg::GAIN_ONE) ? pcd_pkg::GAIN_ONE : cfg.alpha_gain;

  // floor(((1-a)*prev + a*pitch)) == prev + floor(a*(pitch-prev))
  assign diff    = $signed({pitch[15], pitch}) - $signed({prev[15], prev});
  assign prod    = $signed({1'b0, gain}) * diff;
  assign prod_sh = prod >>> 16;
  assign ema     = prev + prod_sh[15:0];

  always_comb begin
    res.climb_started    = enter_hit & ~restart;
    res.nxt.climb_active = active_mid & ~restart;
    res.nxt.entry_time   = res.climb_started ? timestamp_ms : cur.entry_time;
    if (restart) begin
      res.nxt.pitch_bias = 16'd0;
    end else if (active_mid) begin
      res.nxt.pitch_bias = prev;
    end else begin
      res.nxt.pitch_bias = ema;
    end
  end

endmodule

@@ rtl/pitch_climb_detector.sv @@
// Pitch climb detector: one result beat per input beat.
// Path: an input beat is held in the input register, then its result in the result register;
// both stages stall while m_tready holds back an unaccepted result beat.
// Throughput: 1 beat per cycle while m_tready does not hold the output; the bias/flag update
// is combinational step logic (subtracts, compares and one 18x17 multiply).
// Reset (rst, synchronous): configuration registers take their default values, flag and
// bias clear, pipeline empties.
module pitch_climb_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pitch [15:0], timestamp_ms [47:16]
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // climbing [0], climb_started [1], bias_estimate [17:2], zero
);

  pcd_pkg::cfg_t   cfg;
  pcd_pkg::state_t state;
  pcd_pkg::step_t  res;

  logic        in_v;
  logic        in_op;
  logic [15:0] in_pitch;
  logic [31:0] in_time;
  logic        out_v;
  logic        out_climbing;
  logic        out_started;
  logic [15:0] out_bias;
  logic        adv_out;
  logic        fire;

  pcd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pcd_step u_step (
    .operation    (in_op),
    .pitch        (in_pitch),
    .timestamp_ms (in_time),
    .cur          (state),
    .cfg          (cfg),
    .res          (res)
  );

  assign adv_out  = !out_v || m_tready;
  assign fire     = in_v && adv_out;
  assign s_tready = !in_v || adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op    <= s_tuser;
      in_pitch <= s_tdata[15:0];
      in_time  <= s_tdata[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= res.nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv_out) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_climbing <= res.nxt.climb_active;
      out_started  <= res.climb_started;
      out_bias     <= res.nxt.pitch_bias;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {6'd0, out_bias, out_started, out_climbing};

`ifndef SYNTH
  a_start_implies_climb: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (!out_started || out_climbing))
    else $error("climb_started without climbing");

  a_rose_gives_start: assert property (@(posedge clk) disable iff (rst)
    $rose(state.climb_active) |-> (out_v && out_started))
    else $error("climb entry without start beat");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && in_op == pcd_pkg::OP_RESTART) |=> (!state.climb_active && state.pitch_bias == 16'd0))
    else $error("restart did not clear flag and bias");

  a_climb_holds_bias: assert property (@(posedge clk) disable iff (rst)
    (fire && state.climb_active && res.nxt.climb_active) |=> $stable(state.pitch_bias))
    else $error("bias moved while climbing");
`endif

endmodule
